@@ hdl/battery_current_monitor_macros.svh @@
// Assertion macros used by the checker.
`ifndef BATTERY_CURRENT_MONITOR_MACROS_SVH
`define BATTERY_CURRENT_MONITOR_MACROS_SVH

// Checked on every rising edge outside reset.
`define BCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BCM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/bcm_pkg.sv @@
package bcm_pkg;

  localparam int LIM_W   = 19;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 32;
  localparam int INDEX_W = 3;

  localparam logic [INDEX_W-1:0] REG_INVERT_SIGN      = 3'd0;
  localparam logic [INDEX_W-1:0] REG_IDLE_BAND_MA     = 3'd1;
  localparam logic [INDEX_W-1:0] REG_MAX_CHARGE_MA    = 3'd2;
  localparam logic [INDEX_W-1:0] REG_MAX_DISCHARGE_MA = 3'd3;
  localparam logic [INDEX_W-1:0] REG_WARN_LIMIT_MA    = 3'd4;
  localparam logic [INDEX_W-1:0] REG_OC_HOLD_MS       = 3'd5;
  localparam logic [INDEX_W-1:0] REG_HEALTH_LIMIT_MA  = 3'd6;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [1:0] DIR_IDLE      = 2'd0;
  localparam logic [1:0] DIR_DISCHARGE = 2'd1;
  localparam logic [1:0] DIR_CHARGE    = 2'd2;

  localparam logic [LIM_W-1:0]  RST_IDLE_BAND_MA     = 19'd150;
  localparam logic [LIM_W-1:0]  RST_MAX_CHARGE_MA    = 19'd5000;
  localparam logic [LIM_W-1:0]  RST_MAX_DISCHARGE_MA = 19'd10000;
  localparam logic [LIM_W-1:0]  RST_WARN_LIMIT_MA    = 19'd8000;
  localparam logic [TIME_W-1:0] RST_OC_HOLD_MS       = 32'd1000;
  localparam logic [LIM_W-1:0]  RST_HEALTH_LIMIT_MA  = 19'd100000;

  typedef struct packed {
    logic              invert_sign;
    logic [LIM_W-1:0]  idle_band_ma;
    logic [LIM_W-1:0]  max_charge_ma;
    logic [LIM_W-1:0]  max_discharge_ma;
    logic [LIM_W-1:0]  warn_limit_ma;
    logic [TIME_W-1:0] oc_hold_ms;
    logic [LIM_W-1:0]  health_limit_ma;
  } cfg_t;

endpackage

@@ hdl/bcm_if.sv @@
interface bcm_sample_if #(
  parameter int CURRENT_WIDTH = 20
);
  logic                            valid;
  logic                            ready;
  logic                            operation;
  logic signed [CURRENT_WIDTH-1:0] raw_current_ma;
  logic [31:0]                     time_ms;

  modport source (output valid, operation, raw_current_ma, time_ms, input ready);
  modport sink   (input valid, operation, raw_current_ma, time_ms, output ready);
endinterface

interface bcm_result_if #(
  parameter int CURRENT_WIDTH = 20
);
  logic                            valid;
  logic                            ready;
  logic signed [CURRENT_WIDTH-1:0] current_ma;
  logic [1:0]                      direction;
  logic                            over_current;
  logic                            warning;
  logic                            sensor_healthy;
  logic [CURRENT_WIDTH-1:0]        peak_ma;

  modport source (output valid, current_ma, direction, over_current, warning,
                  sensor_healthy, peak_ma, input ready);
  modport sink   (input valid, current_ma, direction, over_current, warning,
                  sensor_healthy, peak_ma, output ready);
endinterface

@@ hdl/bcm_cfg_regs.sv @@
module bcm_cfg_regs
  import bcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata,
  output cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.invert_sign      <= 1'b1;
      cfg.idle_band_ma     <= RST_IDLE_BAND_MA;
      cfg.max_charge_ma    <= RST_MAX_CHARGE_MA;
      cfg.max_discharge_ma <= RST_MAX_DISCHARGE_MA;
      cfg.warn_limit_ma    <= RST_WARN_LIMIT_MA;
      cfg.oc_hold_ms       <= RST_OC_HOLD_MS;
      cfg.health_limit_ma  <= RST_HEALTH_LIMIT_MA;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INVERT_SIGN:      cfg.invert_sign      <= cfg_wdata[0];
        REG_IDLE_BAND_MA:     cfg.idle_band_ma     <= cfg_wdata[LIM_W-1:0];
        REG_MAX_CHARGE_MA:    cfg.max_charge_ma    <= cfg_wdata[LIM_W-1:0];
        REG_MAX_DISCHARGE_MA: cfg.max_discharge_ma <= cfg_wdata[LIM_W-1:0];
        REG_WARN_LIMIT_MA:    cfg.warn_limit_ma    <= cfg_wdata[LIM_W-1:0];
        REG_OC_HOLD_MS:       cfg.oc_hold_ms       <= cfg_wdata[TIME_W-1:0];
        REG_HEALTH_LIMIT_MA:  cfg.health_limit_ma  <= cfg_wdata[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hdl/bcm_in_reg.sv @@
module bcm_in_reg
  import bcm_pkg::*;
#(
  parameter int CURRENT_WIDTH = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  bcm_sample_if.sink                      sample,
  input  logic                            advance,
  output logic                            s1_valid,
  output logic                            s1_op,
  output logic signed [CURRENT_WIDTH-1:0] s1_raw,
  output logic [TIME_W-1:0]               s1_time
);

  logic load;

  assign sample.ready = !s1_valid || advance;
  assign load         = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_op   <= sample.operation;
      s1_raw  <= sample.raw_current_ma;
      s1_time <= sample.time_ms;
    end
  end

endmodule

@@ hdl/bcm_eval.sv @@
module bcm_eval
  import bcm_pkg::*;
#(
  parameter int CURRENT_WIDTH = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  input  cfg_t                            cfg,
  input  logic                            s1_valid,
  input  logic                            s1_op,
  input  logic signed [CURRENT_WIDTH-1:0] s1_raw,
  input  logic [TIME_W-1:0]               s1_time,
  output logic                            advance,
  bcm_result_if.source                    result
);

  localparam int W  = CURRENT_WIDTH;
  localparam int CW = (W > LIM_W) ? W : LIM_W;

  logic [W-1:0]        peak_abs;
  logic                oc_active;
  logic [TIME_W-1:0]   oc_start_time;

  logic                neg_full;
  logic signed [W-1:0] cur;
  logic [W-1:0]        mag;
  logic [CW-1:0]       mag_x;
  logic                beyond_band;
  logic [1:0]          dir;
  logic                raw_oc;
  logic [TIME_W-1:0]   start_sel;
  logic [TIME_W-1:0]   elapsed;
  logic                over;
  logic [W-1:0]        peak_next;
  logic                is_clear;
  logic                fire;

  assign advance  = !result.valid || result.ready;
  assign fire     = s1_valid && advance;
  assign is_clear = (s1_op == OP_CLEAR);

  always_comb begin
    neg_full = (s1_raw == {1'b1, {(W-1){1'b0}}});
    if (cfg.invert_sign) begin
      cur = neg_full ? {1'b0, {(W-1){1'b1}}} : -s1_raw;
    end else begin
      cur = s1_raw;
    end
    mag         = cur[W-1] ? -cur : cur;
    mag_x       = CW'(mag);
    beyond_band = mag_x > CW'(cfg.idle_band_ma);
    if (!beyond_band) begin
      dir = DIR_IDLE;
    end else if (cur[W-1]) begin
      dir = DIR_CHARGE;
    end else begin
      dir = DIR_DISCHARGE;
    end
    unique case (dir)
      DIR_CHARGE:    raw_oc = mag_x > CW'(cfg.max_charge_ma);
      DIR_DISCHARGE: raw_oc = mag_x > CW'(cfg.max_discharge_ma);
      default:       raw_oc = 1'b0;
    endcase
    start_sel = oc_active ? oc_start_time : s1_time;
    elapsed   = s1_time - start_sel;
    over      = raw_oc && (elapsed >= cfg.oc_hold_ms);
    peak_next = (mag > peak_abs) ? mag : peak_abs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_abs      <= '0;
      oc_active     <= 1'b0;
      oc_start_time <= '0;
    end else if (fire) begin
      if (is_clear) begin
        peak_abs <= '0;
      end else begin
        peak_abs <= peak_next;
        if (raw_oc) begin
          if (!oc_active) begin
            oc_active     <= 1'b1;
            oc_start_time <= s1_time;
          end
        end else begin
          oc_active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (is_clear) begin
        result.current_ma     <= '0;
        result.direction      <= DIR_IDLE;
        result.over_current   <= 1'b0;
        result.warning        <= 1'b0;
        result.sensor_healthy <= 1'b0;
        result.peak_ma        <= '0;
      end else begin
        result.current_ma     <= cur;
        result.direction      <= dir;
        result.over_current   <= over;
        result.warning        <= mag_x > CW'(cfg.warn_limit_ma);
        result.sensor_healthy <= mag_x <= CW'(cfg.health_limit_ma);
        result.peak_ma        <= peak_next;
      end
    end
  end

endmodule

@@ hdl/battery_current_monitor.sv @@
// Channel  Role   Carries
// -------  -----  ---------------------------------------------------------
// sample   sink   operation, raw_current_ma, time_ms
// result   source current_ma, direction, over_current, warning,
//                 sensor_healthy, peak_ma
// cfg      write  cfg_we, cfg_index, cfg_wdata (seven registers)
//
// Each request passes through the input register and then the result register,
// from which the result is offered.
// One request is accepted every cycle unless the pipeline is stalled; the peak and
// timer state update in the same cycle that the result register loads.
// A stalled result stops the pipeline; ready falls only when both stages hold.
// Reset is synchronous; it empties both stages and loads the register defaults.
module battery_current_monitor
  import bcm_pkg::*;
#(
  parameter int CURRENT_WIDTH = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata,
  bcm_sample_if.sink         sample,
  bcm_result_if.source       result
);

  cfg_t                            cfg;
  logic                            advance;
  logic                            s1_valid;
  logic                            s1_op;
  logic signed [CURRENT_WIDTH-1:0] s1_raw;
  logic [TIME_W-1:0]               s1_time;

  bcm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bcm_in_reg #(
    .CURRENT_WIDTH (CURRENT_WIDTH)
  ) u_in (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_op    (s1_op),
    .s1_raw   (s1_raw),
    .s1_time  (s1_time)
  );

  bcm_eval #(
    .CURRENT_WIDTH (CURRENT_WIDTH)
  ) u_eval (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_op    (s1_op),
    .s1_raw   (s1_raw),
    .s1_time  (s1_time),
    .advance  (advance),
    .result   (result)
  );

endmodule

@@ hdl/bcm_checker.sv @@
`include "battery_current_monitor_macros.svh"

module bcm_checker
  import bcm_pkg::*;
#(
  parameter int CURRENT_WIDTH = 20
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [CURRENT_WIDTH-1:0] current_ma,
  input logic [1:0]                      direction,
  input logic                            over_current,
  input logic [CURRENT_WIDTH-1:0]        peak_ma
);

  logic [CURRENT_WIDTH-1:0] cur_mag;

  assign cur_mag = current_ma[CURRENT_WIDTH-1] ? -current_ma : current_ma;

  `BCM_ASSERT_ALWAYS(a_reset_empties, rst |=> !out_valid, "result valid after reset")
  `BCM_ASSERT(a_valid_holds, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `BCM_ASSERT(a_oc_not_idle, out_valid |-> !over_current || direction != DIR_IDLE, "overcurrent while idle")
  `BCM_ASSERT(a_peak_covers, out_valid |-> peak_ma >= cur_mag, "peak below present magnitude")

endmodule

bind battery_current_monitor bcm_checker #(
  .CURRENT_WIDTH (CURRENT_WIDTH)
) u_bcm_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .current_ma   (result.current_ma),
  .direction    (result.direction),
  .over_current (result.over_current),
  .peak_ma      (result.peak_ma)
);
